// ===== src/c2rb_pkg.sv =====
package c2rb_pkg;

    localparam int NORM_W   = 58;
    localparam int NORM_TOP = NORM_W - 1;
    localparam int NSTEPS   = 6;
    localparam int SH_W     = 6;
    localparam int VEC_W    = 60;
    localparam int TURN_W   = 32;

    typedef logic [VEC_W-1:0] t_vec;

    localparam logic [TURN_W-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ===== src/c2rb_if.sv =====
interface c2rb_in_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] offset_x;
    logic signed [COORD_BITS-1:0] offset_y;
    logic signed [COORD_BITS-1:0] offset_z;

    modport source (output valid, output offset_x, output offset_y, output offset_z,
                    input ready);
    modport sink (input valid, input offset_x, input offset_y, input offset_z,
                  output ready);
endinterface

interface c2rb_out_if #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] azimuth;
    logic signed [ANGLE_BITS-1:0] elevation;
    logic [COORD_BITS:0]          slant_range;
    logic [COORD_BITS:0]          horizontal_range;

    modport source (output valid, output azimuth, output elevation, output slant_range,
                    output horizontal_range, input ready);
    modport sink (input valid, input azimuth, input elevation, input slant_range,
                  input horizontal_range, output ready);
endinterface

// ===== src/cartesian_to_range_bearing.sv =====
// Throughput: one request per cycle; the pipeline advances as a whole whenever the
// output register is empty or being taken, so a stall holds every stage in place.
// Depth is set by the digit-per-stage square root (COORD_BITS + 59 stages) and the
// CORDIC vectoring stages. Reset is synchronous, active low, and clears valid bits only.
module cartesian_to_range_bearing import c2rb_pkg::*; #(
    parameter int COORD_BITS      = 32,
    parameter int ANGLE_BITS      = 16,
    parameter int ROTATION_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c2rb_in_if.sink     i_in,
    c2rb_out_if.source  o_out
);

    localparam int CB    = COORD_BITS;
    localparam int AB    = ANGLE_BITS;
    localparam int RS    = TURN_W - AB;
    localparam int HSIDE = 3 * NORM_W;
    localparam int ESIDE = 1 + 2 * (CB + 1);
    localparam int RW    = CB + 1 + NORM_TOP;
    localparam logic [TURN_W-1:0]   RND  = TURN_W'((64'd1 << RS) >> 1);
    localparam logic signed [AB:0]  HALF = {2'b01, {(AB-1){1'b0}}};

    logic w_en;

    logic          r1_vld;
    logic [CB-1:0] r1_mx, r1_my, r1_mz;
    logic [2:0]    r1_sg;

    logic            r2_vld;
    logic [2*CB-1:0] r2_sx, r2_sy, r2_sz;
    logic [CB-1:0]   r2_m, r2_mx, r2_my, r2_mz;
    logic [2:0]      r2_sg;

    logic            r3_vld;
    logic [2*CB:0]   r3_h;
    logic [2*CB-1:0] r3_sz;
    logic [CB-1:0]   r3_m, r3_mx, r3_my, r3_mz;
    logic [2:0]      r3_sg;

    logic              r_nvld [NSTEPS];
    logic [NORM_W-1:0] r_nm   [NSTEPS];
    logic [NORM_W-1:0] r_nx   [NSTEPS];
    logic [NORM_W-1:0] r_ny   [NSTEPS];
    logic [NORM_W-1:0] r_nz   [NSTEPS];
    logic [SH_W-1:0]   r_nsh  [NSTEPS];
    logic [2*CB:0]     r_nh   [NSTEPS];
    logic [2*CB+1:0]   r_nt   [NSTEPS];
    logic [2:0]        r_nsg  [NSTEPS];

    logic              n_nvld [NSTEPS];
    logic [NORM_W-1:0] n_nm   [NSTEPS];
    logic [NORM_W-1:0] n_nx   [NSTEPS];
    logic [NORM_W-1:0] n_ny   [NSTEPS];
    logic [NORM_W-1:0] n_nz   [NSTEPS];
    logic [SH_W-1:0]   n_nsh  [NSTEPS];
    logic [2*CB:0]     n_nh   [NSTEPS];
    logic [2*CB+1:0]   n_nt   [NSTEPS];
    logic [2:0]        n_nsg  [NSTEPS];

    logic [CB-1:0] w_mx, w_my, w_mz, w_mxy, w_m;

    logic             h_vld, s_vld;
    logic [CB:0]      h_base;
    logic [RW-1:0]    h_root, s_root;
    logic [HSIDE-1:0] h_side;
    logic [2:0]       s_side;
    logic [NORM_W-1:0] w_ax, w_ay, w_az;
    logic [CB:0]      w_sr;

    logic              az_vld, el_vld;
    logic [TURN_W-2:0] az_ang, el_ang;
    logic [1:0]        az_side;
    logic [ESIDE-1:0]  el_side;

    logic                 r_out_vld;
    logic signed [AB-1:0] r_az, r_el;
    logic [CB:0]          r_sr, r_hr;

    logic [TURN_W-1:0]    w_azq, w_elq;
    logic signed [AB:0]   w_az0, w_az1, w_az2, w_el0, w_el1;

    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    assign w_mx = i_in.offset_x[CB-1] ? CB'(-i_in.offset_x) : CB'(i_in.offset_x);
    assign w_my = i_in.offset_y[CB-1] ? CB'(-i_in.offset_y) : CB'(i_in.offset_y);
    assign w_mz = i_in.offset_z[CB-1] ? CB'(-i_in.offset_z) : CB'(i_in.offset_z);

    assign w_mxy = (r1_mx > r1_my) ? r1_mx : r1_my;
    assign w_m   = (r1_mz > w_mxy) ? r1_mz : w_mxy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mx <= w_mx;
            r1_my <= w_my;
            r1_mz <= w_mz;
            r1_sg <= {i_in.offset_x[CB-1], i_in.offset_y[CB-1], i_in.offset_z[CB-1]};
            r2_sx <= {{CB{1'b0}}, r1_mx} * {{CB{1'b0}}, r1_mx};
            r2_sy <= {{CB{1'b0}}, r1_my} * {{CB{1'b0}}, r1_my};
            r2_sz <= {{CB{1'b0}}, r1_mz} * {{CB{1'b0}}, r1_mz};
            r2_m  <= w_m;
            r2_mx <= r1_mx;
            r2_my <= r1_my;
            r2_mz <= r1_mz;
            r2_sg <= r1_sg;
            r3_h  <= {1'b0, r2_sx} + {1'b0, r2_sy};
            r3_sz <= r2_sz;
            r3_m  <= r2_m;
            r3_mx <= r2_mx;
            r3_my <= r2_my;
            r3_mz <= r2_mz;
            r3_sg <= r2_sg;
        end
    end

    // normalize: shift until the largest magnitude has its top bit at NORM_TOP
    always_comb begin
        logic              sv;
        logic [NORM_W-1:0] sm, sx, sy, sz;
        logic [SH_W-1:0]   ssh;
        logic [2*CB:0]     sh;
        logic [2*CB+1:0]   st;
        logic [2:0]        ssg;
        int                amt;
        for (int j = 0; j < NSTEPS; j++) begin
            amt = 1 << (NSTEPS - 1 - j);
            if (j == 0) begin
                sv  = r3_vld;
                sm  = {{(NORM_W-CB){1'b0}}, r3_m};
                sx  = {{(NORM_W-CB){1'b0}}, r3_mx};
                sy  = {{(NORM_W-CB){1'b0}}, r3_my};
                sz  = {{(NORM_W-CB){1'b0}}, r3_mz};
                ssh = '0;
                sh  = r3_h;
                st  = {1'b0, r3_h} + {2'b00, r3_sz};
                ssg = r3_sg;
            end else begin
                sv  = r_nvld[j-1];
                sm  = r_nm[j-1];
                sx  = r_nx[j-1];
                sy  = r_ny[j-1];
                sz  = r_nz[j-1];
                ssh = r_nsh[j-1];
                sh  = r_nh[j-1];
                st  = r_nt[j-1];
                ssg = r_nsg[j-1];
            end
            n_nvld[j] = sv;
            n_nh[j]   = sh;
            n_nt[j]   = st;
            n_nsg[j]  = ssg;
            if ((sm >> (NORM_W - amt)) == '0) begin
                n_nm[j]  = sm << amt;
                n_nx[j]  = sx << amt;
                n_ny[j]  = sy << amt;
                n_nz[j]  = sz << amt;
                n_nsh[j] = ssh + SH_W'(amt);
            end else begin
                n_nm[j]  = sm;
                n_nx[j]  = sx;
                n_ny[j]  = sy;
                n_nz[j]  = sz;
                n_nsh[j] = ssh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NSTEPS; j++) begin
                r_nvld[j] <= 1'b0;
            end
        end else if (w_en) begin
            for (int j = 0; j < NSTEPS; j++) begin
                r_nvld[j] <= n_nvld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < NSTEPS; j++) begin
                r_nm[j]  <= n_nm[j];
                r_nx[j]  <= n_nx[j];
                r_ny[j]  <= n_ny[j];
                r_nz[j]  <= n_nz[j];
                r_nsh[j] <= n_nsh[j];
                r_nh[j]  <= n_nh[j];
                r_nt[j]  <= n_nt[j];
                r_nsg[j] <= n_nsg[j];
            end
        end
    end

    c2rb_sqrt #(
        .PAIRS  (CB + 1),
        .EXTRA  (NORM_TOP),
        .CNT_W  (SH_W),
        .SIDE_W (HSIDE)
    ) u_hsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_nvld[NSTEPS-1]),
        .i_rad   ({1'b0, r_nh[NSTEPS-1]}),
        .i_ext   (r_nsh[NSTEPS-1]),
        .i_side  ({r_nx[NSTEPS-1], r_ny[NSTEPS-1], r_nz[NSTEPS-1]}),
        .o_valid (h_vld),
        .o_base  (h_base),
        .o_root  (h_root),
        .o_side  (h_side)
    );

    c2rb_sqrt #(
        .PAIRS  (CB + 1),
        .EXTRA  (NORM_TOP),
        .CNT_W  (SH_W),
        .SIDE_W (3)
    ) u_ssqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_nvld[NSTEPS-1]),
        .i_rad   (r_nt[NSTEPS-1]),
        .i_ext   ({SH_W{1'b0}}),
        .i_side  (r_nsg[NSTEPS-1]),
        .o_valid (s_vld),
        .o_base  (),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign w_ax = h_side[HSIDE-1 -: NORM_W];
    assign w_ay = h_side[2*NORM_W-1 -: NORM_W];
    assign w_az = h_side[NORM_W-1:0];
    assign w_sr = s_root[CB:0];

    c2rb_cordic #(
        .STAGES (ROTATION_STAGES),
        .SIDE_W (2)
    ) u_azim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (h_vld && s_vld),
        .i_a     ({2'b00, w_ax}),
        .i_b     ({2'b00, w_ay}),
        .i_side  (s_side[2:1]),
        .o_valid (az_vld),
        .o_angle (az_ang),
        .o_side  (az_side)
    );

    c2rb_cordic #(
        .STAGES (ROTATION_STAGES),
        .SIDE_W (ESIDE)
    ) u_elev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (h_vld && s_vld),
        .i_a     (h_root[VEC_W-1:0]),
        .i_b     ({2'b00, w_az}),
        .i_side  ({s_side[0], h_base, w_sr}),
        .o_valid (el_vld),
        .o_angle (el_ang),
        .o_side  (el_side)
    );

    assign w_azq = ({1'b0, az_ang} + RND) >> RS;
    assign w_elq = ({1'b0, el_ang} + RND) >> RS;
    assign w_az0 = signed'({2'b00, w_azq[AB-2:0]});
    assign w_el0 = signed'({2'b00, w_elq[AB-2:0]});
    assign w_az1 = az_side[1] ? HALF - w_az0 : w_az0;
    assign w_az2 = az_side[0] ? -w_az1 : w_az1;
    assign w_el1 = el_side[ESIDE-1] ? -w_el0 : w_el0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= az_vld && el_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_az <= w_az2[AB-1:0];
            r_el <= w_el1[AB-1:0];
            r_hr <= el_side[2*CB+1 -: CB+1];
            r_sr <= el_side[CB:0];
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.azimuth          = r_az;
    assign o_out.elevation        = r_el;
    assign o_out.slant_range      = r_sr;
    assign o_out.horizontal_range = r_hr;

endmodule

// ===== src/c2rb_sqrt.sv =====
module c2rb_sqrt #(
    parameter int PAIRS  = 33,
    parameter int EXTRA  = 57,
    parameter int CNT_W  = 6,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [2*PAIRS-1:0]       i_rad,
    input  logic [CNT_W-1:0]         i_ext,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [PAIRS-1:0]         o_base,
    output logic [PAIRS+EXTRA-1:0]   o_root,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int RW  = PAIRS + EXTRA;
    localparam int MW  = RW + 3;
    localparam int NST = PAIRS + EXTRA + 1;

    logic [2*PAIRS-1:0] r_rad  [NST];
    logic [MW-1:0]      r_rem  [NST];
    logic [RW-1:0]      r_root [NST];
    logic [CNT_W-1:0]   r_cnt  [NST];
    logic [PAIRS-1:0]   r_base [NST];
    logic [SIDE_W-1:0]  r_side [NST];
    logic               r_vld  [NST];

    logic [2*PAIRS-1:0] n_rad  [NST];
    logic [MW-1:0]      n_rem  [NST];
    logic [RW-1:0]      n_root [NST];
    logic [CNT_W-1:0]   n_cnt  [NST];
    logic [PAIRS-1:0]   n_base [NST];
    logic [SIDE_W-1:0]  n_side [NST];
    logic               n_vld  [NST];

    always_comb begin
        logic [2*PAIRS-1:0] s_rad;
        logic [MW-1:0]      s_rem;
        logic [RW-1:0]      s_root;
        logic [CNT_W-1:0]   s_cnt;
        logic [PAIRS-1:0]   s_base;
        logic [SIDE_W-1:0]  s_side;
        logic               s_vld;
        logic [MW-1:0]      acc;
        logic [MW-1:0]      trial;
        logic               step;
        for (int k = 0; k < NST; k++) begin
            if (k == 0) begin
                s_rad  = i_rad;
                s_rem  = '0;
                s_root = '0;
                s_cnt  = i_ext;
                s_base = '0;
                s_side = i_side;
                s_vld  = i_valid;
            end else begin
                s_rad  = r_rad[k-1];
                s_rem  = r_rem[k-1];
                s_root = r_root[k-1];
                s_cnt  = r_cnt[k-1];
                s_base = r_base[k-1];
                s_side = r_side[k-1];
                s_vld  = r_vld[k-1];
            end
            acc   = {s_rem[MW-3:0], (k < PAIRS) ? s_rad[2*PAIRS-1 -: 2] : 2'b00};
            trial = {1'b0, s_root, 2'b01};
            step  = (k < PAIRS) || ((k < PAIRS + EXTRA) && (k - PAIRS < int'(s_cnt)));
            n_rad[k]  = s_rad << 2;
            n_rem[k]  = s_rem;
            n_root[k] = s_root;
            n_cnt[k]  = s_cnt;
            n_base[k] = s_base;
            n_side[k] = s_side;
            n_vld[k]  = s_vld;
            if (step) begin
                if (acc >= trial) begin
                    n_rem[k]  = acc - trial;
                    n_root[k] = {s_root[RW-2:0], 1'b1};
                end else begin
                    n_rem[k]  = acc;
                    n_root[k] = {s_root[RW-2:0], 1'b0};
                end
            end
            if (k == PAIRS) begin
                n_base[k] = s_root[PAIRS-1:0] + PAIRS'(s_rem > {3'b000, s_root});
            end
            if (k == NST - 1) begin
                n_root[k] = s_root + RW'(s_rem > {3'b000, s_root});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NST; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_cnt[k]  <= n_cnt[k];
                r_base[k] <= n_base[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_base  = r_base[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ===== src/c2rb_cordic.sv =====
module c2rb_cordic import c2rb_pkg::*; #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_vec               i_a,
    input  t_vec               i_b,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [TURN_W-2:0]  o_angle,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int XW  = VEC_W + 2;
    localparam int AW  = TURN_W + 1;
    localparam int NST = STAGES + 1;
    localparam logic signed [AW-1:0] QTR = AW'(64'd1 << (TURN_W - 2));

    logic signed [XW-1:0] r_x   [NST];
    logic signed [XW-1:0] r_y   [NST];
    logic signed [AW-1:0] r_ang [NST];
    logic                 r_bz  [NST];
    logic                 r_az  [NST];
    logic [SIDE_W-1:0]    r_side[NST];
    logic                 r_vld [NST];

    logic signed [XW-1:0] n_x   [NST];
    logic signed [XW-1:0] n_y   [NST];
    logic signed [AW-1:0] n_ang [NST];
    logic                 n_bz  [NST];
    logic                 n_az  [NST];
    logic [SIDE_W-1:0]    n_side[NST];
    logic                 n_vld [NST];

    always_comb begin
        logic signed [XW-1:0] sx;
        logic signed [XW-1:0] sy;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [AW-1:0] sa;
        logic signed [AW-1:0] da;
        logic                 sbz;
        logic                 saz;
        logic [SIDE_W-1:0]    ss;
        logic                 sv;
        for (int k = 0; k < NST; k++) begin
            if (k == 0) begin
                sx  = signed'({2'b00, i_a});
                sy  = signed'({2'b00, i_b});
                sa  = '0;
                sbz = (i_b == '0);
                saz = (i_a == '0);
                ss  = i_side;
                sv  = i_valid;
            end else begin
                sx  = r_x[k-1];
                sy  = r_y[k-1];
                sa  = r_ang[k-1];
                sbz = r_bz[k-1];
                saz = r_az[k-1];
                ss  = r_side[k-1];
                sv  = r_vld[k-1];
            end
            dx = sy >>> k;
            dy = sx >>> k;
            da = signed'({1'b0, ATAN_TAB[k % 32]});
            n_x[k]    = sx;
            n_y[k]    = sy;
            n_ang[k]  = sa;
            n_bz[k]   = sbz;
            n_az[k]   = saz;
            n_side[k] = ss;
            n_vld[k]  = sv;
            if (k < STAGES) begin
                if (!sy[XW-1]) begin
                    n_x[k]   = sx + dx;
                    n_y[k]   = sy - dy;
                    n_ang[k] = sa + da;
                end else begin
                    n_x[k]   = sx - dx;
                    n_y[k]   = sy + dy;
                    n_ang[k] = sa - da;
                end
            end else begin
                if (sbz) begin
                    n_ang[k] = '0;
                end else if (saz) begin
                    n_ang[k] = QTR;
                end else if (sa[AW-1]) begin
                    n_ang[k] = '0;
                end else if (sa > QTR) begin
                    n_ang[k] = QTR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NST; k++) begin
                r_x[k]    <= n_x[k];
                r_y[k]    <= n_y[k];
                r_ang[k]  <= n_ang[k];
                r_bz[k]   <= n_bz[k];
                r_az[k]   <= n_az[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_angle = r_ang[NST-1][TURN_W-2:0];
    assign o_side  = r_side[NST-1];

endmodule

// ===== src/c2rb_checker.sv =====
module c2rb_checker #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [ANGLE_BITS-1:0] i_azimuth,
    input logic signed [ANGLE_BITS-1:0] i_elevation,
    input logic [COORD_BITS:0]          i_slant_range,
    input logic [COORD_BITS:0]          i_horizontal_range
);

    localparam logic signed [ANGLE_BITS-1:0] EL_MAX = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_azimuth) && $stable(i_elevation)
            && $stable(i_slant_range) && $stable(i_horizontal_range))
        else $error("result changed while stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request refused with empty output");

    a_elev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_elevation <= EL_MAX) && (i_elevation >= -EL_MAX))
        else $error("elevation beyond a quarter turn");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_horizontal_range <= i_slant_range)
        else $error("horizontal range above slant range");

endmodule

bind cartesian_to_range_bearing c2rb_checker #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
) u_c2rb_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_azimuth          (o_out.azimuth),
    .i_elevation        (o_out.elevation),
    .i_slant_range      (o_out.slant_range),
    .i_horizontal_range (o_out.horizontal_range)
);
